[rtl/sha_pkg.sv]
// ----------------------------------------------------------------------------
// SHA-256 package
// Round constants, initial hash values and the round helper functions.
// ----------------------------------------------------------------------------
package sha_pkg;

  localparam logic [31:0] K_TAB [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b,
    32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01,
    32'h243185be, 32'h550c7dc3, 32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7,
    32'hc19bf174, 32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da, 32'h983e5152,
    32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
    32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc,
    32'h53380d13, 32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3, 32'hd192e819,
    32'hd6990624, 32'hf40e3585, 32'h106aa070, 32'h19a4c116, 32'h1e376c08,
    32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f,
    32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

  localparam logic [31:0] H_INIT [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

  localparam logic [7:0] PAD_BYTE = 8'h80;
  localparam logic [5:0] LEN_POS  = 6'd56;

  typedef logic [31:0] word_t;

  // start/done handshake between control and compression unit
  typedef struct packed {
    logic start;
  } cmp_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } cmp_sts_t;

  function automatic word_t rotr(input word_t x, input int n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

endpackage

[rtl/sha256_byte_stream_hasher_core.sv]
// ----------------------------------------------------------------------------
// SHA-256 byte stream hasher
// Buffers message bytes, pads at end of message and emits the digest.
// ----------------------------------------------------------------------------
// Usage:
//  s_axis carries one request per item: tdata = msg_byte, tuser =
//  byte_present, tlast = end_of_message. m_axis returns the digest as eight
//  words, word_index 0 (most significant) first, tlast on the eighth word.
//  A byte that does not fill a block is stored, then the next request is
//  taken. The 64th byte of a block starts the round unit, and the next
//  request waits until that compression is done. An end request pads the
//  message and runs one or two compressions, then 8 output words;
//  s_axis_tready stays low until the last word is taken, since the single
//  compression unit and buffer serve one message at a time. When
//  m_axis_tready is low the current word is held. Reset clears the
//  counters, loads the initial hash values and leaves the block ready for
//  a new message.
// ----------------------------------------------------------------------------
module sha256_byte_stream_hasher_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // msg_byte
  input  logic        s_axis_tuser,   // byte_present
  input  logic        s_axis_tlast,   // end_of_message
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // digest_word[31:0], word_index[34:32], 0
  output logic        m_axis_tlast    // last_word
);
  import sha_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_STORE, S_WAIT, S_PAD, S_ZERO, S_LEN, S_EMIT
  } st_t;

  st_t          st;
  logic [31:0]  buf_mem [16];  // block buffer, byte 0 in bits 31:24 of word 0
  logic [5:0]   fill;
  logic [4:0]   lane_lsb;      // low bit of the byte lane at fill
  logic [63:0]  count;
  logic [7:0]   in_byte;
  logic         in_end;
  logic         pad_done;      // 0x80 already written
  logic         final_blk;     // current compression ends the message
  logic [2:0]   widx;
  logic [511:0] blk;
  logic [255:0] hash;
  cmp_req_t     creq;
  cmp_sts_t     csts;
  logic         init_h;
  logic [63:0]  bits;

  assign bits = {count[60:0], 3'b000};
  assign lane_lsb = {~fill[1:0], 3'b000};

  always_comb begin
    for (int i = 0; i < 16; i++) blk[511 - 32*i -: 32] = buf_mem[i];
  end

  sha_compress u_cmp (
    .clk(clk), .rst(rst), .req(creq), .sts(csts),
    .blk(blk), .init_h(init_h), .hash(hash)
  );

  assign s_axis_tready = (st == S_IDLE);
  assign m_axis_tvalid = (st == S_EMIT);
  assign m_axis_tlast  = (widx == 3'd7);
  assign m_axis_tdata  = {5'b0, widx, hash[255 - 32*widx -: 32]};

  // buffer, padding sequencer and output
  always_ff @(posedge clk) begin
    creq.start <= 1'b0;
    init_h     <= 1'b0;
    if (rst) begin
      st    <= S_IDLE;
      fill  <= '0;
      count <= '0;
      widx  <= '0;
      pad_done  <= 1'b0;
      final_blk <= 1'b0;
    end else begin
      case (st)
        S_IDLE: begin
          if (s_axis_tvalid) begin
            in_byte  <= s_axis_tdata;
            in_end   <= s_axis_tlast;
            pad_done <= 1'b0;
            if (s_axis_tuser) st <= S_STORE;
            else if (s_axis_tlast) st <= S_PAD;
          end
        end
        S_STORE: begin
          buf_mem[fill[5:2]][lane_lsb +: 8] <= in_byte;
          count <= count + 64'd1;
          fill  <= fill + 6'd1;
          if (fill == 6'd63) begin
            creq.start <= 1'b1;
            final_blk  <= 1'b0;
            st <= S_WAIT;
          end else begin
            st <= in_end ? S_PAD : S_IDLE;
          end
        end
        S_WAIT: begin
          // after the final block emit; else zero fill if padded, pad at message end, or idle
          if (csts.done) begin
            if (final_blk) begin
              widx <= '0;
              st <= S_EMIT;
            end else if (pad_done) st <= S_ZERO;
            else if (in_end) st <= S_PAD;
            else st <= S_IDLE;
          end
        end
        S_PAD: begin
          buf_mem[fill[5:2]][lane_lsb +: 8] <= PAD_BYTE;
          fill     <= fill + 6'd1;
          pad_done <= 1'b1;
          if (fill == 6'd63) begin
            creq.start <= 1'b1;
            final_blk  <= 1'b0;
            st <= S_WAIT;
          end else st <= S_ZERO;
        end
        S_ZERO: begin
          // zero fill up to the length field, or to block end if past it
          if (fill < LEN_POS && fill != 6'd0) begin
            buf_mem[fill[5:2]][lane_lsb +: 8] <= '0;
            fill <= fill + 6'd1;
          end else if (fill > LEN_POS) begin
            buf_mem[fill[5:2]][lane_lsb +: 8] <= '0;
            fill <= fill + 6'd1;
            if (fill == 6'd63) begin
              creq.start <= 1'b1;
              final_blk  <= 1'b0;
              st <= S_WAIT;
            end
          end else if (fill == 6'd0) begin
            buf_mem[fill[5:2]][lane_lsb +: 8] <= '0;
            fill <= fill + 6'd1;
          end else st <= S_LEN;
        end
        S_LEN: begin
          buf_mem[fill[5:2]][lane_lsb +: 8] <= bits[63 - 8*fill[2:0] -: 8];
          fill <= fill + 6'd1;
          if (fill == 6'd63) begin
            creq.start <= 1'b1;
            final_blk  <= 1'b1;
            st <= S_WAIT;
          end
        end
        S_EMIT: begin
          if (m_axis_tready) begin
            widx <= widx + 3'd1;
            if (widx == 3'd7) begin
              init_h <= 1'b1;
              fill   <= '0;
              count  <= '0;
              st     <= S_IDLE;
            end
          end
        end
        default: st <= S_IDLE;
      endcase
    end
  end

endmodule

[rtl/sha_compress.sv]
// ----------------------------------------------------------------------------
// SHA-256 compression unit
// One round per cycle over a 16-word message schedule window; 64 rounds,
// then a fold step that adds the working variables into the hash words.
// ----------------------------------------------------------------------------
module sha_compress (
  input  logic                   clk,
  input  logic                   rst,
  input  sha_pkg::cmp_req_t      req,
  output sha_pkg::cmp_sts_t      sts,
  input  logic [511:0]           blk,     // byte 0 in bits 511:504
  input  logic                   init_h,  // reload initial hash values
  output logic [255:0]           hash     // word 0 in bits 255:224
);
  import sha_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_RUN, S_FOLD} st_t;

  st_t        st;
  logic [5:0] rnd;
  logic       fold_done;
  word_t      w [16];
  word_t      v [8];
  word_t      h [8];
  word_t      s0, s1, wn, t1, t2;

  // schedule and round datapath
  always_comb begin
    s0 = rotr(w[1], 7) ^ rotr(w[1], 18) ^ (w[1] >> 3);
    s1 = rotr(w[14], 17) ^ rotr(w[14], 19) ^ (w[14] >> 10);
    wn = w[0] + s0 + w[9] + s1;
    t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25)) +
         ((v[4] & v[5]) ^ (~v[4] & v[6])) + K_TAB[rnd] + w[0];
    t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22)) +
         ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
  end

  // sequencer and state
  always_ff @(posedge clk) begin
    fold_done <= 1'b0;
    if (rst) begin
      st  <= S_IDLE;
      rnd <= '0;
      for (int i = 0; i < 8; i++) h[i] <= H_INIT[i];
    end else begin
      case (st)
        S_IDLE: begin
          if (init_h) begin
            for (int i = 0; i < 8; i++) h[i] <= H_INIT[i];
          end
          if (req.start) begin
            for (int i = 0; i < 16; i++) w[i] <= blk[511 - 32*i -: 32];
            for (int i = 0; i < 8; i++) v[i] <= h[i];
            rnd <= '0;
            st  <= S_RUN;
          end
        end
        S_RUN: begin
          for (int i = 0; i < 15; i++) w[i] <= w[i+1];
          w[15] <= wn;
          for (int i = 1; i < 8; i++) v[i] <= v[i-1];
          v[4] <= v[3] + t1;
          v[0] <= t1 + t2;
          rnd  <= rnd + 6'd1;
          if (rnd == 6'd63) st <= S_FOLD;
        end
        S_FOLD: begin
          for (int i = 0; i < 8; i++) h[i] <= h[i] + v[i];
          fold_done <= 1'b1;
          st <= S_IDLE;
        end
        default: st <= S_IDLE;
      endcase
    end
  end

  assign sts = '{busy: (st != S_IDLE), done: fold_done};

  always_comb begin
    for (int i = 0; i < 8; i++) hash[255 - 32*i -: 32] = h[i];
  end

endmodule

[dv/sha256_stream_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-256 stream checker
// Watches both stream channels, computes the expected digest words from the
// accepted byte requests and compares every returned word against them.
// ----------------------------------------------------------------------------
module sha256_stream_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // msg_byte
  input  logic        s_axis_tuser,   // byte_present
  input  logic        s_axis_tlast,   // end_of_message
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [39:0] m_axis_tdata,   // digest_word[31:0], word_index[34:32], 0
  input  logic        m_axis_tlast,   // last_word
  output int          fail_count,
  output int          words_pending
);
  import sha_pkg::*;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } digest_entry_t;

  digest_entry_t digest_q[$];

  word_t       hash_state [8];
  logic [7:0]  blk_bytes [64];
  int unsigned blk_fill;
  logic [63:0] byte_total;

  function automatic word_t ror(word_t x, int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  // one full compression of blk_bytes into hash_state
  task automatic compress_blk();
    word_t w [64];
    word_t v [8];
    word_t t1, t2, s0, s1;
    for (int i = 0; i < 16; i++)
      w[i] = {blk_bytes[4*i], blk_bytes[4*i+1], blk_bytes[4*i+2], blk_bytes[4*i+3]};
    for (int i = 16; i < 64; i++) begin
      s0 = ror(w[i-15], 7) ^ ror(w[i-15], 18) ^ (w[i-15] >> 3);
      s1 = ror(w[i-2], 17) ^ ror(w[i-2], 19) ^ (w[i-2] >> 10);
      w[i] = w[i-16] + s0 + w[i-7] + s1;
    end
    v = hash_state;
    for (int i = 0; i < 64; i++) begin
      t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25)) +
           ((v[4] & v[5]) ^ (~v[4] & v[6])) + K_TAB[i] + w[i];
      t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22)) +
           ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
      v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) hash_state[i] += v[i];
  endtask

  task automatic clear_msg();
    hash_state = H_INIT;
    blk_fill   = 0;
    byte_total = '0;
  endtask

  // absorb one request; on end of message pad and queue the digest words
  task automatic absorb_request(logic [7:0] b, logic present, logic eom);
    logic [63:0]   bit_len;
    digest_entry_t e;
    if (present) begin
      blk_bytes[blk_fill] = b;
      blk_fill++;
      byte_total++;
      if (blk_fill == 64) begin
        compress_blk();
        blk_fill = 0;
      end
    end
    if (eom) begin
      bit_len = byte_total << 3;
      blk_bytes[blk_fill] = PAD_BYTE;
      blk_fill++;
      if (blk_fill > LEN_POS) begin
        for (int i = blk_fill; i < 64; i++) blk_bytes[i] = 8'h00;
        compress_blk();
        blk_fill = 0;
      end
      for (int i = blk_fill; i < LEN_POS; i++) blk_bytes[i] = 8'h00;
      for (int i = 0; i < 8; i++) blk_bytes[LEN_POS + i] = bit_len[8*(7-i) +: 8];
      compress_blk();
      for (int i = 0; i < 8; i++) begin
        e.digest_word = hash_state[i];
        e.word_index  = 3'(i);
        e.last_word   = (i == 7);
        digest_q.insert(digest_q.size(), e);
      end
      clear_msg();
    end
  endtask

  always @(posedge clk) begin
    digest_entry_t exp_e, got_e;
    if (rst) begin
      clear_msg();
      digest_q.delete();
      fail_count <= 0;
      words_pending <= 0;
    end else begin
      // output side first: a request finishing this edge cannot be seen yet
      if (m_axis_tvalid && m_axis_tready) begin
        got_e.digest_word = m_axis_tdata[31:0];
        got_e.word_index  = m_axis_tdata[34:32];
        got_e.last_word   = m_axis_tlast;
        if (digest_q.size() == 0) begin
          if (fail_count < 10)
            $display("ERROR: unexpected digest word %h idx %0d", got_e.digest_word,
                     got_e.word_index);
          fail_count <= fail_count + 1;
        end else begin
          exp_e = digest_q.pop_front();
          if (exp_e !== got_e || m_axis_tdata[39:35] !== 5'd0) begin
            if (fail_count < 10)
              $display("ERROR: digest mismatch exp %h/%0d/%0d got %h/%0d/%0d",
                       exp_e.digest_word, exp_e.word_index, exp_e.last_word,
                       got_e.digest_word, got_e.word_index, got_e.last_word);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready)
        absorb_request(s_axis_tdata, s_axis_tuser, s_axis_tlast);
      words_pending <= digest_q.size();
    end
  end
endmodule

[dv/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-256 byte stream hasher testbench
// Drives directed and random messages with random idling and a long output
// stall; the checker predicts and compares every digest word.
// ----------------------------------------------------------------------------
module testbench;
  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;
  logic        s_axis_tuser = 1'b0;
  logic        s_axis_tlast = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;
  logic        m_axis_tlast;
  int          fail_count;
  int          words_pending;
  int          idle_cycles = 0;
  bit          calm_out = 1'b0;
  bit          hold_out = 1'b0;
  bit          stim_done = 1'b0;

  localparam int WATCHDOG_LIMIT = 20000;

  always #5 clk = ~clk;

  sha256_byte_stream_hasher_core u_top (.*);

  sha256_stream_checker u_chk (.*);

  // send one request; idles at random unless calm, valid stays up back to back
  task automatic send_request(logic [7:0] b, logic present, logic eom, bit calm);
    while (!calm && $urandom_range(99) < 30) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tuser  <= present;
    s_axis_tlast  <= eom;
    do @(posedge clk); while (!s_axis_tready);
  endtask

  task automatic send_message(int n, bit calm, bit empty_end);
    for (int i = 0; i < n; i++) begin
      // occasional idle requests carrying no byte
      if ($urandom_range(9) == 0) send_request(8'($urandom), 1'b0, 1'b0, calm);
      send_request(8'($urandom), 1'b1, (i == n - 1) && !empty_end, calm);
    end
    if (empty_end || n == 0) send_request(8'($urandom), 1'b0, 1'b1, calm);
  endtask

  // receiver: random stalls, calm stretch, and a forced long hold-off
  always @(posedge clk) begin
    if (rst) m_axis_tready <= 1'b0;
    else if (hold_out) m_axis_tready <= 1'b0;
    else m_axis_tready <= calm_out || ($urandom_range(99) >= 30);
  end

  initial begin
    #1;
    hold_out = 1'b0;
    wait (!rst);
    wait (words_pending > 0);
    @(posedge clk);
    hold_out = 1'b1;
    repeat (400) @(posedge clk);
    hold_out = 1'b0;
  end

  // watchdog on cycles without any request moving
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cycles <= 0;
    else if (stim_done && words_pending == 0)
      idle_cycles <= 0;
    else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("sha256_byte_stream_hasher_core verification failed");
        $finish;
      end
    end
  end

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // directed: empty message, one- and two-byte messages with extreme byte values
    send_request(8'h00, 1'b0, 1'b1, 1'b0);
    send_request(8'hff, 1'b1, 1'b1, 1'b0);
    send_request(8'h00, 1'b1, 1'b0, 1'b0);
    send_request(8'h55, 1'b0, 1'b0, 1'b0);
    send_request(8'haa, 1'b1, 1'b1, 1'b0);
    // long stretch without idling on either side
    calm_out = 1'b1;
    send_message(60, 1'b1, 1'b0);
    calm_out = 1'b0;
    // short random messages
    for (int m = 0; m < 8; m++) begin
      send_message($urandom_range(6), 1'b0, $urandom_range(3) == 0);
    end
    s_axis_tvalid <= 1'b0;
    stim_done = 1'b1;
    @(posedge clk);
    while (words_pending > 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (fail_count == 0)
      $display("sha256_byte_stream_hasher_core verification clean");
    else
      $display("sha256_byte_stream_hasher_core verification failed");
    $finish;
  end
endmodule
